// File: rtl/kf2_pkg.sv
// ----------------------------------------------------------------------------
// kf2_pkg
// Shared types, constants, sequencer states and saturating Q16.16 helpers
// for the two-state Kalman filter step.
// ----------------------------------------------------------------------------
package kf2_pkg;

  localparam int unsigned QW       = 32;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned NOISE_W  = 31;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DVD_W    = QW + FRAC_W;
  localparam int unsigned DCNT_W   = $clog2(DVD_W);

  typedef logic signed [QW-1:0] q16_t;
  typedef logic signed [QW:0]   q16x_t;

  localparam q16_t Q_ONE = q16_t'(32'sd65536);
  localparam q16_t Q_MAX = q16_t'(32'sh7fff_ffff);
  localparam q16_t Q_MIN = q16_t'(32'sh8000_0000);

  localparam logic [DT_W-1:0]    DT_RST    = DT_W'(13107);
  localparam logic [NOISE_W-1:0] QNOISE_RST = NOISE_W'(655);
  localparam logic [NOISE_W-1:0] RNOISE_RST = NOISE_W'(655);

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_TIME_STEP  = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_MEAS_NOISE = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_XP0, ST_XP1, ST_PRED, ST_SNS, ST_DET0, ST_DET1, ST_DET2, ST_CHK,
    ST_INVG, ST_INVW,
    ST_K0A, ST_K0B, ST_K1A, ST_K1B, ST_K2A, ST_K2B, ST_K3A, ST_K3B,
    ST_E0A, ST_E0B, ST_E1A, ST_E1B, ST_E2,
    ST_C0A, ST_C0B, ST_C1A, ST_C1B, ST_C2A, ST_C2B, ST_C3A, ST_C3B, ST_C4,
    ST_OUT
  } kf2_state_t;

  function automatic q16_t q_sat33(input q16x_t s);
    q16_t r;
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic q16_t q_add(input q16_t a, input q16_t b);
    q16x_t s;
    s = {a[QW-1], a} + {b[QW-1], b};
    return q_sat33(s);
  endfunction

  function automatic q16_t q_sub(input q16_t a, input q16_t b);
    q16x_t s;
    s = {a[QW-1], a} - {b[QW-1], b};
    return q_sat33(s);
  endfunction

endpackage

// File: rtl/kf2_mul.sv
// ----------------------------------------------------------------------------
// kf2_mul
// Shared Q16.16 multiplier: registered 32x32 product, then round to nearest
// (half up), floor shift and saturate to 32 bits.
// ----------------------------------------------------------------------------
module kf2_mul (
  input  logic          clk,
  input  kf2_pkg::q16_t a,
  input  kf2_pkg::q16_t b,
  output kf2_pkg::q16_t res
);
  import kf2_pkg::*;

  logic signed [2*QW-1:0]        prod_r;
  logic signed [2*QW-1:0]        rnd;
  logic signed [2*QW-FRAC_W-1:0] sh;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_comb begin
    rnd = prod_r + (2*QW)'(64'sd32768);
    sh  = rnd[2*QW-1:FRAC_W];
    if ((&sh[2*QW-FRAC_W-1:QW-1]) || !(|sh[2*QW-FRAC_W-1:QW-1])) begin
      res = sh[QW-1:0];
    end else begin
      res = sh[2*QW-FRAC_W-1] ? Q_MIN : Q_MAX;
    end
  end

endmodule

// File: rtl/kf2_div.sv
// ----------------------------------------------------------------------------
// kf2_div
// Restoring divider, one quotient bit per cycle: (num * 2^16) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module kf2_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  kf2_pkg::q16x_t num,
  input  kf2_pkg::q16_t den,
  output logic          done,
  output kf2_pkg::q16_t quo
);
  import kf2_pkg::*;

  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [QW-1:0]     rem_r;
  logic [QW-1:0]     dmag_r;
  logic              neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  q16x_t             num_neg;
  logic [QW-1:0]     num_mag;
  logic [QW-1:0]     den_mag;
  logic [QW:0]       trial;
  logic [QW:0]       diff;
  logic              ge;
  logic              big_pos;
  logic              big_neg;

  always_comb begin
    num_neg = -num;
    num_mag = num[QW] ? num_neg[QW-1:0] : num[QW-1:0];
    den_mag = den[QW-1] ? QW'(-den) : QW'(den);
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, dmag_r};
    ge      = (trial >= {1'b0, dmag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {num_mag, {FRAC_W{1'b0}}};
      quo_r  <= '0;
      rem_r  <= '0;
      dmag_r <= den_mag;
      neg_r  <= num[QW] ^ den[QW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[QW-1:0] : trial[QW-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    big_pos = |quo_r[DVD_W-1:QW-1];
    big_neg = (|quo_r[DVD_W-1:QW]) || (quo_r[QW-1] && (|quo_r[QW-2:0]));
    if (neg_r) begin
      quo = big_neg ? Q_MIN : q16_t'(-quo_r[QW-1:0]);
    end else begin
      quo = big_pos ? Q_MAX : q16_t'(quo_r[QW-1:0]);
    end
  end

  assign done = done_r;

endmodule

// File: rtl/kalman_filter_2state_step_top.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state_step_top
// Two-state Kalman filter step in Q16.16 with saturating arithmetic.
//
// Input channel (in_valid/in_ready) takes one item: control vector and
// measurement vector. Result channel (out_valid/out_ready) returns the
// updated estimate and a singular flag per item. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_wdata): time step, process noise and
// measurement noise; write only while idle.
// Each item runs the shared 48-step restoring divider four times for the
// inverse and issues 24 multiplies through the single shared multiplier;
// when the innovation determinant is zero the sequence skips the inverse
// and the correction and goes straight to the result.
// in_ready is high only while the sequencer is idle, one item at a time:
// a new item is taken only after the previous result has been loaded into
// the output register.
// A finished result sits in an output register; a stalled receiver holds
// only the final state until that register frees, and a new item is taken
// while the old result still waits. Synchronous reset clears the estimate
// and covariance and restores default register values.
// ----------------------------------------------------------------------------
module kalman_filter_2state_step_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kf2_pkg::q16_t                  in_control_0,
  input  kf2_pkg::q16_t                  in_control_1,
  input  kf2_pkg::q16_t                  in_measure_0,
  input  kf2_pkg::q16_t                  in_measure_1,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kf2_pkg::q16_t                  out_estimate_0,
  output kf2_pkg::q16_t                  out_estimate_1,
  output logic                           out_singular,
  input  logic                           cfg_we,
  input  logic [kf2_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [kf2_pkg::CFG_W-1:0]      cfg_wdata
);
  import kf2_pkg::*;

  kf2_state_t           state_r, state_nxt;
  logic [DT_W-1:0]      dt_r;
  logic [NOISE_W-1:0]   qn_r;
  logic [NOISE_W-1:0]   rn_r;
  q16_t                 x_r [2];
  q16_t                 p_r [4];
  q16_t                 u_r [2];
  q16_t                 z_r [2];
  q16_t                 y_r [2];
  q16_t                 k_r [4];
  q16_t                 inv_r [4];
  q16_t                 s0_r, s3_r, det_r, acc_r;
  logic [1:0]           idx_r;
  logic                 sing_r;
  logic                 out_valid_r;
  q16_t                 out_est0_r, out_est1_r;
  logic                 out_sing_r;

  q16_t                 mul_a, mul_b, mul_res;
  q16_t                 dt_q, qn_q, rn_q;
  logic                 div_start, div_done;
  q16x_t                div_num;
  q16_t                 div_quo;
  logic                 out_free;
  logic                 in_acc;

  assign dt_q     = q16_t'({{(QW-DT_W){1'b0}}, dt_r});
  assign qn_q     = q16_t'({{(QW-NOISE_W){1'b0}}, qn_r});
  assign rn_q     = q16_t'({{(QW-NOISE_W){1'b0}}, rn_r});
  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  kf2_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  kf2_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_XP0;
      ST_XP0:  state_nxt = ST_XP1;
      ST_XP1:  state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_SNS;
      ST_SNS:  state_nxt = ST_DET0;
      ST_DET0: state_nxt = ST_DET1;
      ST_DET1: state_nxt = ST_DET2;
      ST_DET2: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (det_r == '0) ? ST_OUT : ST_INVG;
      ST_INVG: state_nxt = ST_INVW;
      ST_INVW: begin
        if (div_done) state_nxt = (idx_r == 2'd3) ? ST_K0A : ST_INVG;
      end
      ST_K0A:  state_nxt = ST_K0B;
      ST_K0B:  state_nxt = ST_K1A;
      ST_K1A:  state_nxt = ST_K1B;
      ST_K1B:  state_nxt = ST_K2A;
      ST_K2A:  state_nxt = ST_K2B;
      ST_K2B:  state_nxt = ST_K3A;
      ST_K3A:  state_nxt = ST_K3B;
      ST_K3B:  state_nxt = ST_E0A;
      ST_E0A:  state_nxt = ST_E0B;
      ST_E0B:  state_nxt = ST_E1A;
      ST_E1A:  state_nxt = ST_E1B;
      ST_E1B:  state_nxt = ST_E2;
      ST_E2:   state_nxt = ST_C0A;
      ST_C0A:  state_nxt = ST_C0B;
      ST_C0B:  state_nxt = ST_C1A;
      ST_C1A:  state_nxt = ST_C1B;
      ST_C1B:  state_nxt = ST_C2A;
      ST_C2A:  state_nxt = ST_C2B;
      ST_C2B:  state_nxt = ST_C3A;
      ST_C3A:  state_nxt = ST_C3B;
      ST_C3B:  state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    div_start = (state_r == ST_INVG);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_XP0:  begin mul_a = dt_q;     mul_b = u_r[0];   end
      ST_XP1:  begin mul_a = dt_q;     mul_b = u_r[1];   end
      ST_DET0: begin mul_a = s0_r;     mul_b = s3_r;     end
      ST_DET1: begin mul_a = p_r[1];   mul_b = p_r[2];   end
      ST_K0A:  begin mul_a = p_r[0];   mul_b = inv_r[0]; end
      ST_K0B:  begin mul_a = p_r[1];   mul_b = inv_r[2]; end
      ST_K1A:  begin mul_a = p_r[0];   mul_b = inv_r[1]; end
      ST_K1B:  begin mul_a = p_r[1];   mul_b = inv_r[3]; end
      ST_K2A:  begin mul_a = p_r[2];   mul_b = inv_r[0]; end
      ST_K2B:  begin mul_a = p_r[3];   mul_b = inv_r[2]; end
      ST_K3A:  begin mul_a = p_r[2];   mul_b = inv_r[1]; end
      ST_K3B:  begin mul_a = p_r[3];   mul_b = inv_r[3]; end
      ST_E0A:  begin mul_a = k_r[0];   mul_b = y_r[0];   end
      ST_E0B:  begin mul_a = k_r[1];   mul_b = y_r[1];   end
      ST_E1A:  begin mul_a = k_r[2];   mul_b = y_r[0];   end
      ST_E1B:  begin mul_a = k_r[3];   mul_b = y_r[1];   end
      ST_C0A:  begin mul_a = k_r[0];   mul_b = p_r[0];   end
      ST_C0B:  begin mul_a = k_r[1];   mul_b = p_r[2];   end
      ST_C1A:  begin mul_a = k_r[0];   mul_b = p_r[1];   end
      ST_C1B:  begin mul_a = k_r[1];   mul_b = p_r[3];   end
      ST_C2A:  begin mul_a = k_r[2];   mul_b = p_r[0];   end
      ST_C2B:  begin mul_a = k_r[3];   mul_b = p_r[2];   end
      ST_C3A:  begin mul_a = k_r[2];   mul_b = p_r[1];   end
      ST_C3B:  begin mul_a = k_r[3];   mul_b = p_r[3];   end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
    unique case (idx_r)
      2'd0:    div_num = {s3_r[QW-1], s3_r};
      2'd1:    div_num = -{p_r[1][QW-1], p_r[1]};
      2'd2:    div_num = -{p_r[2][QW-1], p_r[2]};
      default: div_num = {s0_r[QW-1], s0_r};
    endcase
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dt_r        <= DT_RST;
      qn_r        <= QNOISE_RST;
      rn_r        <= RNOISE_RST;
      out_valid_r <= 1'b0;
      x_r[0]      <= '0;
      x_r[1]      <= '0;
      p_r[0]      <= '0;
      p_r[1]      <= '0;
      p_r[2]      <= '0;
      p_r[3]      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIME_STEP:  dt_r <= cfg_wdata[DT_W-1:0];
          CFG_PROC_NOISE: qn_r <= cfg_wdata[NOISE_W-1:0];
          CFG_MEAS_NOISE: rn_r <= cfg_wdata[NOISE_W-1:0];
          default:        ;
        endcase
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_XP1:  x_r[0] <= q_add(x_r[0], mul_res);
        ST_PRED: begin
          x_r[1] <= q_add(x_r[1], mul_res);
          p_r[0] <= q_add(p_r[0], qn_q);
          p_r[3] <= q_add(p_r[3], qn_q);
        end
        ST_E1A:  x_r[0] <= q_add(x_r[0], q_add(acc_r, mul_res));
        ST_E2:   x_r[1] <= q_add(x_r[1], q_add(acc_r, mul_res));
        ST_C4: begin
          p_r[0] <= inv_r[0];
          p_r[1] <= inv_r[1];
          p_r[2] <= inv_r[2];
          p_r[3] <= q_add(acc_r, mul_res);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (state_r == ST_CHK) begin
      idx_r <= '0;
    end else if (state_r == ST_INVW && div_done) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          u_r[0] <= in_control_0;
          u_r[1] <= in_control_1;
          z_r[0] <= in_measure_0;
          z_r[1] <= in_measure_1;
        end
      end
      ST_SNS: begin
        s0_r <= q_add(p_r[0], rn_q);
        s3_r <= q_add(p_r[3], rn_q);
      end
      ST_DET1: acc_r <= mul_res;
      ST_DET2: det_r <= q_sub(acc_r, mul_res);
      ST_CHK:  sing_r <= (det_r == '0);
      ST_INVW: if (div_done) inv_r[idx_r] <= div_quo;
      ST_K0B, ST_K1B, ST_K2B, ST_E0B, ST_E1B,
      ST_C0B, ST_C1B, ST_C2B, ST_C3B: acc_r <= mul_res;
      ST_K1A:  k_r[0] <= q_add(acc_r, mul_res);
      ST_K2A:  k_r[1] <= q_add(acc_r, mul_res);
      ST_K3A:  k_r[2] <= q_add(acc_r, mul_res);
      ST_K3B: begin
        acc_r  <= mul_res;
        y_r[0] <= q_sub(z_r[0], x_r[0]);
        y_r[1] <= q_sub(z_r[1], x_r[1]);
      end
      ST_E0A:  k_r[3] <= q_add(acc_r, mul_res);
      ST_E2: begin
        // turn the gain into I - K in place
        k_r[0] <= q_sub(Q_ONE, k_r[0]);
        k_r[1] <= q_sub('0, k_r[1]);
        k_r[2] <= q_sub('0, k_r[2]);
        k_r[3] <= q_sub(Q_ONE, k_r[3]);
      end
      ST_C1A:  inv_r[0] <= q_add(acc_r, mul_res);
      ST_C2A:  inv_r[1] <= q_add(acc_r, mul_res);
      ST_C3A:  inv_r[2] <= q_add(acc_r, mul_res);
      ST_OUT: begin
        if (out_free) begin
          out_est0_r <= x_r[0];
          out_est1_r <= x_r[1];
          out_sing_r <= sing_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_estimate_0 = out_est0_r;
  assign out_estimate_1 = out_est1_r;
  assign out_singular   = out_sing_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_XP0)
    else $error("accepted item did not start the sequence");

  a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_INVW)
    else $error("divider finished outside the wait state");

  a_singular_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && det_r == '0) |=> state_r == ST_OUT)
    else $error("zero determinant did not skip the correction");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output state");

endmodule
